### rtl/sliding_window_median_alarm_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window median alarm
// Shared property wrappers that report failures through $error.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_ALARM_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ALARM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWMA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/swma_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median alarm package
// Sizes, register map and the types shared by the sorted cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package swma_pkg;

   localparam int WINDOW      = 64;
   localparam int DATA_W      = 32;
   localparam int CNT_W       = $clog2(WINDOW + 1);
   localparam int PTR_W       = $clog2(WINDOW);
   localparam int CNT_OUT_W   = 7;
   localparam int CNT_EXT_W   = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
   localparam int MIN_SAMPLES = 5;

   // Median selection tree: groups of GROUP_SIZE cells are reduced first.
   localparam int GROUP_SIZE  = 8;
   localparam int NUM_GROUPS  = (WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam int THR_W       = 31;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(600);

   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WARN_THRESHOLD = CSR_ADDR_W'(0);

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;

   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};

   // One entry of the sorted chain.
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
   } cell_entry_type;

   // Broadcast command to every cell of the chain.
   typedef struct packed {
      logic                     remove;
      logic                     insert;
      logic signed [DATA_W-1:0] key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### rtl/swma_cell.sv
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one entry of the ascending window and trades it with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module swma_cell (
   input  wire                               clock,
   input  wire                               reset,
   input  wire swma_pkg::cell_ctrl_type      ctrl,
   input  wire swma_pkg::cell_entry_type     left,
   input  wire swma_pkg::cell_entry_type     right,
   input  wire                               sel,
   output swma_pkg::cell_entry_type          q,
   output logic [swma_pkg::DATA_W-1:0]       gated
);

   logic                               valid_ff, valid_in;
   logic signed [swma_pkg::DATA_W-1:0] value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.remove) begin
         // Every entry at or above the evicted value moves down by one place,
         // which drops exactly one copy of it.
         if (valid_ff && (value_ff >= ctrl.key)) begin
            valid_in = right.valid;
            value_in = right.value;
         end
      end else if (ctrl.insert) begin
         priority if ((valid_ff && (value_ff <= ctrl.key)) || (!valid_ff && !left.valid)) begin
            valid_in = valid_ff;
         end else if (left.valid && (left.value > ctrl.key)) begin
            valid_in = 1'b1;
            value_in = left.value;
         end else begin
            valid_in = 1'b1;
            value_in = ctrl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign q.valid = valid_ff;
   assign q.value = value_ff;
   assign gated   = sel ? value_ff : '0;

endmodule

`default_nettype wire

### rtl/swma_median_tree.sv
// ----------------------------------------------------------------------------
// Median selection tree
// Two registered OR levels that pick the one selected cell out of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module swma_median_tree (
   input  wire                            clock,
   input  wire [swma_pkg::DATA_W-1:0]     gated [swma_pkg::WINDOW],
   output logic [swma_pkg::DATA_W-1:0]    median
);

   logic [swma_pkg::DATA_W-1:0] group_ff [swma_pkg::NUM_GROUPS];
   logic [swma_pkg::DATA_W-1:0] group_in [swma_pkg::NUM_GROUPS];
   logic [swma_pkg::DATA_W-1:0] result_ff, result_in;

   always_comb begin
      for (int g = 0; g < swma_pkg::NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < swma_pkg::GROUP_SIZE; k++) begin
            if (g * swma_pkg::GROUP_SIZE + k < swma_pkg::WINDOW) begin
               group_in[g] = group_in[g] | gated[g * swma_pkg::GROUP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      result_in = '0;
      for (int g = 0; g < swma_pkg::NUM_GROUPS; g++) begin
         result_in = result_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff  <= group_in;
      result_ff <= result_in;
   end

   assign median = result_ff;

endmodule

`default_nettype wire

### rtl/sliding_window_median_alarm.sv
// ----------------------------------------------------------------------------
// Sliding window median alarm
// Running median of the most recent clock offset samples with a sync alarm.
// ----------------------------------------------------------------------------
// Usage:
//   Offset samples arrive on the req_ stream, one signed 32-bit sample per
//   transfer. Each sample produces one transfer on the rsp_ stream carrying
//   the window median, the out-of-sync flag and the number of held samples.
//   The alarm threshold is written through the csr_ port (register 0).
//   Once the window is full, the oldest sample is first pulled out of the
//   sorted cell chain before the new one is inserted. The chain does one
//   broadcast update per cycle, and the median is picked through a two-level
//   registered tree. A new sample is taken as soon as the previous one has
//   reached the output register, so no new sample is taken while one is in
//   progress in the chain or the tree.
//   If the receiver stalls, the finished result waits in the output register;
//   the next sample is still taken and then holds before its output step.
//   Reset (synchronous, active high) empties the window, sets the threshold
//   to 600 and drops any pending result. There is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_median_alarm_assert.svh"

module sliding_window_median_alarm (
   input  wire                                 clock,
   input  wire                                 reset,
   // req_tdata: offset[31:0]
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [swma_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: median[31:0], out_of_sync[32], sample_count[39:33]
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [swma_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [swma_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire [swma_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [swma_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // Sequencer: one-hot states.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_REMOVE = 6'b000010,
      S_INSERT = 6'b000100,
      S_TREE1  = 6'b001000,
      S_TREE2  = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [swma_pkg::THR_W-1:0]          thr_ff, thr_in;
   logic [swma_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [swma_pkg::PTR_W-1:0]          oldest_ff, oldest_in;
   logic                                full_ff, full_in;
   logic signed [swma_pkg::DATA_W-1:0]  sample_ff, sample_in;
   logic signed [swma_pkg::DATA_W-1:0]  evict_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [swma_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // Arrival-order ring, read at the oldest slot every cycle.
   logic signed [swma_pkg::DATA_W-1:0]  ring [swma_pkg::WINDOW];
   logic [swma_pkg::PTR_W-1:0]          ring_waddr;
   logic [swma_pkg::PTR_W:0]            slot_sum;

   logic req_xfer;
   logic csr_write;
   logic rsp_load;
   logic full_now;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign full_now   = (count_ff == swma_pkg::CNT_W'(swma_pkg::WINDOW));
   assign rsp_load   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Configuration port: single register, always ready.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == swma_pkg::ADDR_WARN_THRESHOLD) ?
                       swma_pkg::CSR_DATA_W'(thr_ff) : '0;

   always_comb begin
      thr_in = thr_ff;
      if (csr_write && (csr_paddr == swma_pkg::ADDR_WARN_THRESHOLD)) begin
         thr_in = csr_pwdata[swma_pkg::THR_W-1:0];
      end
   end

   // While filling, the new slot sits count places past the oldest one.
   assign slot_sum   = {1'b0, oldest_ff} + (swma_pkg::PTR_W+1)'(count_ff);
   assign ring_waddr = full_now ? oldest_ff :
                       (slot_sum >= (swma_pkg::PTR_W+1)'(swma_pkg::WINDOW)) ?
                       swma_pkg::PTR_W'(slot_sum - (swma_pkg::PTR_W+1)'(swma_pkg::WINDOW)) :
                       slot_sum[swma_pkg::PTR_W-1:0];

   // The read captured at the transfer edge still sees the old contents of
   // the slot being overwritten, which is the sample to evict.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ring[ring_waddr] <= $signed(req_tdata);
      end
      evict_ff <= ring[oldest_ff];
   end

   // Sorted cell chain.
   swma_pkg::cell_ctrl_type  cell_ctrl;
   swma_pkg::cell_entry_type cell_q [swma_pkg::WINDOW];
   logic [swma_pkg::DATA_W-1:0] cell_gated [swma_pkg::WINDOW];
   logic [swma_pkg::WINDOW-1:0] cell_valid;
   logic [swma_pkg::CNT_W-1:0]  median_index;
   logic [swma_pkg::DATA_W-1:0] tree_median;

   assign cell_ctrl.remove = (state_ff == S_REMOVE);
   assign cell_ctrl.insert = (state_ff == S_INSERT);
   assign cell_ctrl.key    = (state_ff == S_REMOVE) ? evict_ff : sample_ff;
   assign median_index     = count_ff >> 1;

   for (genvar j = 0; j < swma_pkg::WINDOW; j++) begin : g_cell
      swma_pkg::cell_entry_type left_entry, right_entry;

      // The chain's lower end looks like a valid entry no sample is below,
      // and its upper end like an empty one.
      if (j == 0) begin : g_low_end
         assign left_entry.valid = 1'b1;
         assign left_entry.value = swma_pkg::MOST_NEGATIVE;
      end else begin : g_low_link
         assign left_entry = cell_q[j-1];
      end

      if (j == swma_pkg::WINDOW - 1) begin : g_high_end
         assign right_entry.valid = 1'b0;
         assign right_entry.value = '0;
      end else begin : g_high_link
         assign right_entry = cell_q[j+1];
      end

      swma_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (cell_ctrl),
         .left  (left_entry),
         .right (right_entry),
         .sel   (median_index == swma_pkg::CNT_W'(j)),
         .q     (cell_q[j]),
         .gated (cell_gated[j])
      );

      assign cell_valid[j] = cell_q[j].valid;
   end

   swma_median_tree u_tree (
      .clock  (clock),
      .gated  (cell_gated),
      .median (tree_median)
   );

   // Result assembly: short windows report zero, and the most negative
   // median counts as one above it for the alarm.
   logic signed [swma_pkg::DATA_W-1:0] median_out;
   logic [swma_pkg::DATA_W-1:0]        mag_full;
   logic [swma_pkg::THR_W-1:0]         mag;
   logic                               out_of_sync;
   logic [swma_pkg::CNT_EXT_W-1:0]     count_ext;

   assign median_out  = (count_ff >= swma_pkg::CNT_W'(swma_pkg::MIN_SAMPLES)) ?
                        $signed(tree_median) : '0;
   assign mag_full    = median_out[swma_pkg::DATA_W-1] ? (~median_out + 1'b1) : median_out;
   assign mag         = mag_full[swma_pkg::DATA_W-1] ? '1 : mag_full[swma_pkg::THR_W-1:0];
   assign out_of_sync = (mag > thr_ff);
   assign count_ext   = swma_pkg::CNT_EXT_W'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      full_in      = full_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               sample_in = $signed(req_tdata);
               full_in   = full_now;
               if (full_now) begin
                  oldest_in = (oldest_ff == swma_pkg::PTR_W'(swma_pkg::WINDOW - 1)) ?
                              '0 : oldest_ff + 1'b1;
                  state_in  = S_REMOVE;
               end else begin
                  state_in  = S_INSERT;
               end
            end
         end
         S_REMOVE: begin
            state_in = S_INSERT;
         end
         S_INSERT: begin
            if (!full_ff) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_TREE1;
         end
         S_TREE1: begin
            state_in = S_TREE2;
         end
         S_TREE2: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {count_ext[swma_pkg::CNT_OUT_W-1:0], out_of_sync, median_out};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= swma_pkg::THR_RESET;
         count_ff     <= '0;
         oldest_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fill count never passes the window size.
   `SWMA_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1,
                     count_ff <= swma_pkg::CNT_W'(swma_pkg::WINDOW))
   // Between samples the chain holds exactly as many entries as the count.
   `SWMA_ASSERT_SAME(a_chain_matches_count, clock, reset, state_ff == S_IDLE,
                     $countones(cell_valid) == count_ff)
   // Eviction only happens on a full window.
   `SWMA_ASSERT_SAME(a_remove_when_full, clock, reset, state_ff == S_REMOVE,
                     count_ff == swma_pkg::CNT_W'(swma_pkg::WINDOW))
   // A sample transfer always starts the sequencer.
   `SWMA_ASSERT_NEXT(a_xfer_starts_work, clock, reset, req_xfer,
                     state_ff == S_REMOVE || state_ff == S_INSERT)
   // Leaving the output step always leaves a result in the output register.
   `SWMA_ASSERT_NEXT(a_emit_loads_output, clock, reset, rsp_load, rsp_valid_ff)

endmodule

`default_nettype wire
